// File: rtl/qlbb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-lane bandpass biquad.
// No dependencies; used by qlbb_regs, qlbb_lane and the top level.
package qlbb_pkg;

  localparam int COEF_BITS = 32;
  localparam int RND_W     = 65;
  localparam int ADDR_W    = 4;
  localparam int STEP_W    = 3;

  localparam logic [1:0] REG_FEED_GAIN   = 2'd0;
  localparam logic [1:0] REG_FB_GAIN_ONE = 2'd1;
  localparam logic [1:0] REG_FB_GAIN_TWO = 2'd2;
  localparam logic [1:0] REG_NORM_RECIP  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_MUL_X    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_X2   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_Y1   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_Y2   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ACC_LAST = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SCALE    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_NORM = 3'd6;
  localparam logic [STEP_W-1:0] STEP_OUT      = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] feed_gain;
    logic signed [COEF_BITS-1:0] fb_gain_one;
    logic signed [COEF_BITS-1:0] fb_gain_two;
    logic signed [COEF_BITS-1:0] norm_recip;
  } coef_t;

  typedef struct packed {
    logic              start;
    logic              clr;
    logic              run;
    logic [STEP_W-1:0] step;
  } lane_ctrl_t;

endpackage

// File: rtl/qlbb_regs.sv
`timescale 1ns / 1ps
// APB coefficient register file of the biquad.
// Depends on qlbb_pkg.
module qlbb_regs #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qlbb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output qlbb_pkg::coef_t            coef_o
);

  localparam int CW = qlbb_pkg::COEF_BITS;
  localparam logic signed [CW-1:0] RECIP_ONE = CW'(1) << COEF_FRAC_BITS;

  qlbb_pkg::coef_t coef_q;
  logic            wr_en;
  logic [1:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.feed_gain   <= '0;
      coef_q.fb_gain_one <= '0;
      coef_q.fb_gain_two <= '0;
      coef_q.norm_recip  <= RECIP_ONE;
    end else if (wr_en) begin
      unique case (idx)
        qlbb_pkg::REG_FEED_GAIN:   coef_q.feed_gain   <= pwdata;
        qlbb_pkg::REG_FB_GAIN_ONE: coef_q.fb_gain_one <= pwdata;
        qlbb_pkg::REG_FB_GAIN_TWO: coef_q.fb_gain_two <= pwdata;
        qlbb_pkg::REG_NORM_RECIP:  coef_q.norm_recip  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qlbb_pkg::REG_FEED_GAIN:   prdata = coef_q.feed_gain;
      qlbb_pkg::REG_FB_GAIN_ONE: prdata = coef_q.fb_gain_one;
      qlbb_pkg::REG_FB_GAIN_TWO: prdata = coef_q.fb_gain_two;
      qlbb_pkg::REG_NORM_RECIP:  prdata = coef_q.norm_recip;
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: rtl/qlbb_lane.sv
`timescale 1ns / 1ps
// One biquad lane: shared 32x32 multiplier stepped over the four taps and the
// final normalization, plus the lane's delay line. Depends on qlbb_pkg.
module qlbb_lane #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qlbb_pkg::lane_ctrl_t          ctrl_i,
  input  qlbb_pkg::coef_t               coef_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int CW    = qlbb_pkg::COEF_BITS;
  localparam int RW    = qlbb_pkg::RND_W;
  localparam int ACC_W = (CW + SAMPLE_BITS + 2 > 64) ? 64 : CW + SAMPLE_BITS + 2;
  localparam logic signed [RW-1:0] HALF = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q, y1_q, y2_q, y_q, y_d;
  logic signed [CW-1:0]          a_op, b_op, t_q, t_d;
  logic signed [2*CW-1:0]        mul, prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic                          neg_q;
  logic signed [RW-1:0]          sum_a, rs_a, sum_y, rs_y;
  logic [RW-CW:0]                hi_a;
  logic [RW-SAMPLE_BITS:0]       hi_y;

  always_comb begin
    unique case (ctrl_i.step)
      qlbb_pkg::STEP_MUL_X:    begin a_op = coef_i.feed_gain;   b_op = CW'(x_q);  end
      qlbb_pkg::STEP_MUL_X2:   begin a_op = coef_i.feed_gain;   b_op = CW'(x2_q); end
      qlbb_pkg::STEP_MUL_Y1:   begin a_op = coef_i.fb_gain_one; b_op = CW'(y1_q); end
      qlbb_pkg::STEP_MUL_Y2:   begin a_op = coef_i.fb_gain_two; b_op = CW'(y2_q); end
      qlbb_pkg::STEP_MUL_NORM: begin a_op = coef_i.norm_recip;  b_op = t_q;       end
      default:                 begin a_op = coef_i.feed_gain;   b_op = CW'(x_q);  end
    endcase
  end

  assign mul = a_op * b_op;

  // round half up, then saturate to 32 bits
  assign sum_a = RW'(acc_q) + HALF;
  assign rs_a  = sum_a >>> COEF_FRAC_BITS;
  assign hi_a  = rs_a[RW-1:CW-1];
  assign t_d   = (&hi_a || ~|hi_a) ? rs_a[CW-1:0] : (rs_a[RW-1] ? T_MIN : T_MAX);

  // normalization product back to sample width
  assign sum_y = RW'(prod_q) + HALF;
  assign rs_y  = sum_y >>> COEF_FRAC_BITS;
  assign hi_y  = rs_y[RW-1:SAMPLE_BITS-1];
  assign y_d   = (&hi_y || ~|hi_y) ? rs_y[SAMPLE_BITS-1:0] : (rs_y[RW-1] ? Y_MIN : Y_MAX);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q <= sample_i;
    end
    if (ctrl_i.run) begin
      prod_q <= mul;
      neg_q  <= (ctrl_i.step == qlbb_pkg::STEP_MUL_X2) ||
                (ctrl_i.step == qlbb_pkg::STEP_MUL_Y1) ||
                (ctrl_i.step == qlbb_pkg::STEP_MUL_Y2);
      if (ctrl_i.step == qlbb_pkg::STEP_MUL_X) begin
        acc_q <= '0;
      end else if (ctrl_i.step <= qlbb_pkg::STEP_ACC_LAST) begin
        acc_q <= neg_q ? acc_q - $signed(prod_q[ACC_W-1:0])
                       : acc_q + $signed(prod_q[ACC_W-1:0]);
      end
      if (ctrl_i.step == qlbb_pkg::STEP_SCALE) begin
        t_q <= t_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      y_q  <= '0;
    end else if (ctrl_i.clr) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      y_q  <= '0;
    end else if (ctrl_i.run && ctrl_i.step == qlbb_pkg::STEP_OUT) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_d;
      y_q  <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// File: rtl/qlbb_merge.sv
`timescale 1ns / 1ps
// Merging stage: packs the lane results into the output register that drives
// the master stream. No dependencies.
module qlbb_merge #(
  parameter int LANES       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [LANES-1:0][SAMPLE_BITS-1:0]     lane_y_i,
  output logic                                  can_load_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int TDATA_W = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

  logic               valid_q, valid_d;
  logic [TDATA_W-1:0] data_q;

  assign can_load_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= TDATA_W'(lane_y_i);
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// File: rtl/quad_lane_bandpass_biquad.sv
`timescale 1ns / 1ps
// Top level of the four-lane bandpass biquad: sequencer, lanes, merge stage.
// Depends on qlbb_pkg, qlbb_regs, qlbb_lane and qlbb_merge.
//
// Usage:
//  - Slave stream s_axis: tdata carries one Q1.23 sample per lane, lane 0 in
//    the low bits; tuser is the op flag (0 filter, 1 clear all history).
//  - Master stream m_axis: tdata carries one filtered sample per lane, same
//    packing; a clear returns all zeros.
//  - APB port: b0, a1, a2 and 1/a0 in Q8.24 at byte addresses 0, 4, 8, 12.
//    Write only while the block is idle.
//  - Each lane computes a filter transfer with a single 32x32 multiplier
//    stepped over four taps and the final scaling, plus a rounding stage;
//    a clear skips these steps. One item is in the lanes at a time, so a
//    new item is taken only after the last one has left them.
//  - The output register holds a result while the receiver stalls; the next
//    item is taken and computed meanwhile and then waits inside the lanes
//    until the output register frees.
//  - Reset clears all history, sets b0, a1, a2 to zero and 1/a0 to one.
module quad_lane_bandpass_biquad #(
  parameter int LANES          = 4,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // slave stream
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // sample_lane0 .. sample_lane(LANES-1), lowest first, zero padded
  input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  logic                                   s_axis_tuser_i,
  // master stream
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // filtered_lane0 .. filtered_lane(LANES-1), lowest first, zero padded
  output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qlbb_pkg::ADDR_W-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  qlbb_pkg::seq_state_e              state_q, state_d;
  logic [qlbb_pkg::STEP_W-1:0]       step_q, step_d;
  qlbb_pkg::lane_ctrl_t              ctrl;
  qlbb_pkg::coef_t                   coef;
  logic                              accept, load, can_load;
  logic [LANES-1:0][SAMPLE_BITS-1:0] lane_y;

  assign s_axis_tready_o = (state_q == qlbb_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign load            = (state_q == qlbb_pkg::ST_HOLD) && can_load;

  assign ctrl.start = accept & ~s_axis_tuser_i;
  assign ctrl.clr   = accept & s_axis_tuser_i;
  assign ctrl.run   = (state_q == qlbb_pkg::ST_RUN);
  assign ctrl.step  = step_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      qlbb_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = s_axis_tuser_i ? qlbb_pkg::ST_HOLD : qlbb_pkg::ST_RUN;
          step_d  = qlbb_pkg::STEP_MUL_X;
        end
      end
      qlbb_pkg::ST_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == qlbb_pkg::STEP_OUT) begin
          state_d = qlbb_pkg::ST_HOLD;
        end
      end
      qlbb_pkg::ST_HOLD: begin
        if (can_load) begin
          state_d = qlbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qlbb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qlbb_pkg::ST_IDLE;
      step_q  <= qlbb_pkg::STEP_MUL_X;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  qlbb_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    qlbb_lane #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .coef_i  (coef),
      .sample_i($signed(s_axis_tdata_i[l*SAMPLE_BITS +: SAMPLE_BITS])),
      .y_o     (lane_y[l])
    );
  end

  qlbb_merge #(
    .LANES      (LANES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .lane_y_i       (lane_y),
    .can_load_o     (can_load),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

`ifndef ASSERT_OFF
  a_clear_to_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i) |=> (state_q == qlbb_pkg::ST_HOLD))
    else $error("clear transfer did not go straight to result hold");

  a_filter_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !s_axis_tuser_i) |=>
      (state_q == qlbb_pkg::ST_RUN && step_q == qlbb_pkg::STEP_MUL_X))
    else $error("filter transfer did not start at the first tap");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qlbb_pkg::ST_RUN && step_q == qlbb_pkg::STEP_OUT) |=>
      (state_q == qlbb_pkg::ST_HOLD))
    else $error("sequencer did not finish after the last step");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == qlbb_pkg::ST_HOLD))
    else $error("output became valid without a finished item");
`endif

endmodule
